FILE: design/averaged_signed_seven_segment_display_macros.svh
// Assertion macros shared by the display driver modules.
`ifndef AVERAGED_SIGNED_SEVEN_SEGMENT_DISPLAY_MACROS_SVH
`define AVERAGED_SIGNED_SEVEN_SEGMENT_DISPLAY_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off while arst_n is low
`define ASSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSD_ASSERT_NOW(lbl, ante, cons, msg)
`define ASSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/assd_pkg.sv
// Types, constants and the segment decoder of the display driver.
package assd_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 13;
	localparam int AVG_W    = 10;
	localparam int POS_W    = 2;
	localparam int SEG_W    = 8;

	localparam logic [AVG_W-1:0] OFFSET = 10'd512;

	typedef logic [3:0] glyph_t;
	localparam glyph_t GLYPH_MINUS = 4'd10;

	localparam logic [POS_W-1:0] POS_UNITS = 2'd0;
	localparam logic [POS_W-1:0] POS_TENS  = 2'd1;
	localparam logic [POS_W-1:0] POS_HUND  = 2'd2;
	localparam logic [POS_W-1:0] POS_LEFT  = 2'd3;

	// sign, hundreds digit and the remainder below one hundred
	typedef struct packed {
		logic       neg;
		logic [2:0] hund;
		logic [6:0] rem;
	} split_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [SEG_W-1:0] seg;
	} write_t;

	// active low, decimal point off; anything past nine shows a minus
	function automatic logic [SEG_W-1:0] seg_of(glyph_t g);
		logic [SEG_W-1:0] s;
		case (g)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hBF;
		endcase
		return s;
	endfunction

endpackage

FILE: design/assd_ifs.sv
// Valid/ready channel interfaces for samples and digit writes.
interface assd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [assd_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface assd_digit_if;
	logic                       valid;
	logic                       ready;
	logic [assd_pkg::POS_W-1:0] digit_position;
	logic [assd_pkg::SEG_W-1:0] segments;
	logic                       last_write;

	modport source(output valid, output digit_position, output segments,
		output last_write, input ready);
	modport sink(input valid, input digit_position, input segments,
		input last_write, output ready);
endinterface

FILE: design/assd_accum.sv
// Sample accumulator, divide by a constant and the held average register.
`include "averaged_signed_seven_segment_display_macros.svh"
module assd_accum #(
	parameter int SAMPLES_PER_AVERAGE = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	assd_sample_if.sink                  samples,
	output logic                         held_v,
	input  logic                         held_rdy,
	output logic [assd_pkg::AVG_W-1:0]   held
);

	localparam int CNT_W   = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
	localparam int SHIFT   = 17;
	localparam int RECIP_W = SHIFT + 1;
	// ceil(2^17/N) is exact for any 13-bit sum when N <= 8
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2**SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);
	localparam int PROD_W = assd_pkg::SUM_W + RECIP_W;

	logic [assd_pkg::SUM_W-1:0] sum_q, sum_next, sum_s1;
	logic [CNT_W-1:0]           count_q;
	logic                       hit, hit_s1;
	logic                       v_s1, v_s2;
	logic                       acc, adv_s1, rdy_s2;
	logic [PROD_W-1:0]          prod;
	logic [assd_pkg::AVG_W-1:0] quot, held_q;

	assign acc      = samples.valid && samples.ready;
	assign sum_next = sum_q + assd_pkg::SUM_W'(samples.sample);
	assign hit      = (count_q == CNT_LAST);

	assign rdy_s2        = !v_s2 || held_rdy;
	assign adv_s1        = v_s1 && rdy_s2;
	assign samples.ready = !v_s1 || rdy_s2;

	assign prod = {{RECIP_W{1'b0}}, sum_s1} * {{assd_pkg::SUM_W{1'b0}}, RECIP};
	assign quot = prod[SHIFT +: assd_pkg::AVG_W];

	assign held_v = v_s2;
	assign held   = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			held_q  <= '0;
		end else begin
			if (acc) begin
				if (hit) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_q + 1'b1;
				end
			end
			if (acc)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (adv_s1)
				v_s2 <= 1'b1;
			else if (held_rdy)
				v_s2 <= 1'b0;
			// the average moves on only as a word enters s2, so s2 sees its own value
			if (adv_s1 && hit_s1)
				held_q <= quot;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sum_s1 <= sum_next;
			hit_s1 <= hit;
		end
	end

	`ASSD_ASSERT_NEXT(a_sum_clear, acc && hit, sum_q == '0 && count_q == '0, "sum not cleared after average")
	`ASSD_ASSERT_NEXT(a_held_stable, v_s2 && !held_rdy, $stable(held_q), "average changed under stalled word")

endmodule

FILE: design/assd_digits.sv
// Offset removal, sign and hundreds split of the held average.
module assd_digits (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       held_v,
	output logic                       held_rdy,
	input  logic [assd_pkg::AVG_W-1:0] held,
	output logic                       split_v,
	input  logic                       split_rdy,
	output assd_pkg::split_t           split
);

	logic                       neg;
	logic [assd_pkg::AVG_W-1:0] mag;
	logic [2:0]                 hund;
	logic [assd_pkg::AVG_W-1:0] base;
	logic                       v_s3;
	assd_pkg::split_t           split_s3;

	assign neg = held < assd_pkg::OFFSET;
	assign mag = neg ? (assd_pkg::OFFSET - held) : (held - assd_pkg::OFFSET);

	// magnitude is at most 512, so the hundreds digit is 0..5
	always_comb begin
		if (mag >= 10'd500) begin
			hund = 3'd5;
			base = 10'd500;
		end else if (mag >= 10'd400) begin
			hund = 3'd4;
			base = 10'd400;
		end else if (mag >= 10'd300) begin
			hund = 3'd3;
			base = 10'd300;
		end else if (mag >= 10'd200) begin
			hund = 3'd2;
			base = 10'd200;
		end else if (mag >= 10'd100) begin
			hund = 3'd1;
			base = 10'd100;
		end else begin
			hund = 3'd0;
			base = 10'd0;
		end
	end

	assign held_rdy = !v_s3 || split_rdy;
	assign split_v  = v_s3;
	assign split    = split_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (held_v && held_rdy)
			v_s3 <= 1'b1;
		else if (split_rdy)
			v_s3 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (held_v && held_rdy) begin
			split_s3.neg  <= neg;
			split_s3.hund <= hund;
			split_s3.rem  <= 7'(mag - base);
		end
	end

endmodule

FILE: design/assd_seq.sv
// Tens and units split, write list build and the digit write sequencer.
`include "averaged_signed_seven_segment_display_macros.svh"
module assd_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             split_v,
	output logic             split_rdy,
	input  assd_pkg::split_t split,
	assd_digit_if.source     digits
);

	logic [14:0]       tens_prod;
	logic [3:0]        d2, d1;
	logic [6:0]        tens_val;
	logic [1:0]        lead_pos;
	logic [1:0]        n;
	logic [1:0]        last_d;
	assd_pkg::write_t  ents_d [4];
	assd_pkg::write_t  ents_q [4];
	logic [1:0]        idx_q, last_q;
	logic              v_q;
	logic              fire, is_last, load;

	// rem < 100, so rem*205 >> 11 is rem/10 exactly
	assign tens_prod = 15'(split.rem) * 15'd205;
	assign d2        = tens_prod[14:11];
	assign tens_val  = 7'({3'b000, d2} * 7'd10);
	assign d1        = 4'(split.rem - tens_val);

	always_comb begin
		if (split.hund != 3'd0)
			lead_pos = assd_pkg::POS_LEFT;
		else if (d2 != 4'd0)
			lead_pos = assd_pkg::POS_HUND;
		else
			lead_pos = assd_pkg::POS_TENS;
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			ents_d[i] = '{pos: assd_pkg::POS_UNITS, seg: assd_pkg::seg_of(assd_pkg::GLYPH_MINUS)};
		n = 2'd0;
		if (split.neg) begin
			ents_d[n] = '{pos: lead_pos, seg: assd_pkg::seg_of(assd_pkg::GLYPH_MINUS)};
			n = n + 2'd1;
		end
		if (split.hund != 3'd0 || d2 != 4'd0) begin
			ents_d[n] = '{pos: assd_pkg::POS_TENS, seg: assd_pkg::seg_of(d2)};
			n = n + 2'd1;
		end
		// hundreds goes out after tens
		if (split.hund != 3'd0) begin
			ents_d[n] = '{pos: assd_pkg::POS_HUND, seg: assd_pkg::seg_of({1'b0, split.hund})};
			n = n + 2'd1;
		end
		ents_d[n] = '{pos: assd_pkg::POS_UNITS, seg: assd_pkg::seg_of(d1)};
		last_d = n;
	end

	assign is_last   = (idx_q == last_q);
	assign fire      = v_q && digits.ready;
	assign split_rdy = !v_q || (digits.ready && is_last);
	assign load      = split_v && split_rdy;

	assign digits.valid          = v_q;
	assign digits.digit_position = ents_q[idx_q].pos;
	assign digits.segments       = ents_q[idx_q].seg;
	assign digits.last_write     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
		end else if (load) begin
			v_q    <= 1'b1;
			idx_q  <= '0;
			last_q <= last_d;
		end else if (fire) begin
			if (is_last)
				v_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ents_q <= ents_d;
	end

	`ASSD_ASSERT_NOW(a_idx_range, v_q, idx_q <= last_q, "write index past last write")
	`ASSD_ASSERT_NEXT(a_idx_step, fire && !is_last, v_q && idx_q == $past(idx_q) + 2'd1, "write index did not advance")

endmodule

FILE: design/averaged_signed_seven_segment_display.sv
// A sample's first digit write is valid once its word has passed stages s1, s2 and s3.
// Throughput: one digit write per cycle while the output is ready; a sample makes 1 to 4 writes
// on the single output port, and the next sample is accepted while writes are still going out.
// The pipeline holds one word in each of its four stages and stalls from the output back.
// Reset (arst_n low) clears the running sum, the count and the held average to zero
// and empties every stage.
module averaged_signed_seven_segment_display #(
	parameter int SAMPLES_PER_AVERAGE = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	assd_sample_if.sink  samples,
	assd_digit_if.source digits
);

	logic                       held_v, held_rdy;
	logic [assd_pkg::AVG_W-1:0] held;
	logic                       split_v, split_rdy;
	assd_pkg::split_t           split;

	assd_accum #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.held_v   (held_v),
		.held_rdy (held_rdy),
		.held     (held)
	);

	assd_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.held_v    (held_v),
		.held_rdy  (held_rdy),
		.held      (held),
		.split_v   (split_v),
		.split_rdy (split_rdy),
		.split     (split)
	);

	assd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.split_v   (split_v),
		.split_rdy (split_rdy),
		.split     (split),
		.digits    (digits)
	);

endmodule
